FILE: rtl/core/brrp_pkg.sv
// ----------------------------------------------------------------------------
// brrp_pkg
// Shared types and constants of the bitmap row remap parser.
// ----------------------------------------------------------------------------
package brrp_pkg;

    // remap table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int BYTE_W      = 8;
    localparam int TADDR_W     = $clog2(TABLE_DEPTH);

    // field and counter widths
    localparam int DIM_W    = 11;
    localparam int STRIDE_W = 12;
    localparam int ROW_W    = 10;
    localparam int OFF_W    = 21;
    localparam int RUN_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [OFF_W-1:0] OFFSET_MAX = {OFF_W{1'b1}};
    localparam logic [STRIDE_W-1:0] HDR_BYTES = STRIDE_W'(4);

    // input word opcodes
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_DATA  = 2'd2
    } t_opcode;

    // output byte kinds
    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_PAD    = 2'd2
    } t_kind;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_COLUMN = 3'd2,
        CFG_HEADER = 3'd3,
        CFG_STRIDE = 3'd4
    } t_cfg_idx;

    // configuration registers as seen by the sequencer
    typedef struct packed {
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic                column_order;
        logic                header_mode;
        logic [STRIDE_W-1:0] stride;
    } t_cfg;

    // per-byte tags that travel beside the table read
    typedef struct packed {
        logic [BYTE_W-1:0] raw;
        t_kind             kind;
        logic [ROW_W-1:0]  row;
        logic              begins;
        logic [OFF_W-1:0]  offset;
        logic              done;
        logic              bad;
    } t_meta;

endpackage

FILE: rtl/core/brrp_ram.sv
// ----------------------------------------------------------------------------
// brrp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/brrp_ctrl.sv
// ----------------------------------------------------------------------------
// brrp_ctrl
// Row sequencer: latches geometry at start, walks header, pixel and padding
// bytes, and tags each data word with row, offset and end marks.
// ----------------------------------------------------------------------------
module brrp_ctrl
    import brrp_pkg::*;
#(
    parameter int MAX_DIMENSION = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_opcode,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  t_cfg              i_cfg,
    output logic              o_res_valid,
    output t_meta             o_meta
);

    localparam int MD_W  = $clog2(MAX_DIMENSION + 1);
    localparam int CMP_W = (MD_W > DIM_W) ? MD_W : DIM_W;
    localparam logic [CMP_W-1:0] CAP_EXT = CMP_W'(MAX_DIMENSION);
    localparam logic [DIM_W-1:0] CAP     = DIM_W'(MAX_DIMENSION);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        return (ext > CAP_EXT) ? CAP : v;
    endfunction

    // latched geometry
    logic [DIM_W-1:0]    r_rows, n_rows;
    logic [DIM_W-1:0]    r_cols, n_cols;
    logic [STRIDE_W-1:0] r_row_len, n_row_len;
    logic                r_hdr, n_hdr;
    logic                r_active, n_active;

    // walking state
    logic [DIM_W-1:0]    r_row, n_row;
    logic [STRIDE_W-1:0] r_bin, n_bin;
    logic [23:0]         r_shift, n_shift;
    logic [RUN_W-1:0]    r_run, n_run;
    logic [OFF_W-1:0]    r_off, n_off;

    logic                data_hit;
    logic [DIM_W-1:0]    st_rows, st_cols;
    logic [STRIDE_W:0]   bin_inc;
    logic [RUN_W-1:0]    hdr_first, hdr_last, run_dec;
    logic                end_row;
    logic [DIM_W:0]      row_inc;

    assign data_hit    = i_accept && (i_opcode == OP_DATA) && r_active;
    assign o_res_valid = data_hit;

    assign st_rows   = clamp_dim(i_cfg.column_order ? i_cfg.width : i_cfg.height);
    assign st_cols   = clamp_dim(i_cfg.column_order ? i_cfg.height : i_cfg.width);
    assign bin_inc   = {1'b0, r_bin} + 1'b1;
    assign hdr_first = r_shift[23:8];
    assign hdr_last  = {r_shift[7:0], i_data_byte};
    assign run_dec   = (r_run != '0) ? r_run - 1'b1 : '0;
    assign row_inc   = {1'b0, r_row} + 1'b1;

    // next state and result tags
    always_comb begin
        n_rows    = r_rows;
        n_cols    = r_cols;
        n_row_len = r_row_len;
        n_hdr     = r_hdr;
        n_active  = r_active;
        n_row     = r_row;
        n_bin     = r_bin;
        n_shift   = r_shift;
        n_run     = r_run;
        n_off     = r_off;
        end_row   = 1'b0;

        o_meta        = '0;
        o_meta.raw    = i_data_byte;
        o_meta.row    = r_row[ROW_W-1:0];
        o_meta.offset = r_off;
        o_meta.kind   = KIND_PIXEL;

        if (i_accept && (i_opcode == OP_START)) begin
            // latch geometry and rewind
            n_rows    = st_rows;
            n_cols    = st_cols;
            n_row_len = (i_cfg.stride > STRIDE_W'(st_cols)) ? i_cfg.stride
                                                            : STRIDE_W'(st_cols);
            n_hdr     = i_cfg.header_mode;
            n_row     = '0;
            n_bin     = '0;
            n_shift   = '0;
            n_run     = '0;
            n_off     = '0;
            n_active  = (st_rows != '0) &&
                        (i_cfg.header_mode || (n_row_len != '0));
        end else if (data_hit) begin
            if (!r_hdr) begin
                // fixed rows: pixels then padding
                o_meta.begins = (r_bin == '0);
                o_meta.kind   = (r_bin < STRIDE_W'(r_cols)) ? KIND_PIXEL : KIND_PAD;
                n_bin         = bin_inc[STRIDE_W-1:0];
                end_row       = (bin_inc >= {1'b0, r_row_len});
            end else if (r_bin < HDR_BYTES) begin
                // header bytes, big-endian first then last
                o_meta.begins = (r_bin == '0);
                o_meta.kind   = KIND_HEADER;
                if (r_bin < (HDR_BYTES - 1'b1)) begin
                    n_shift = {r_shift[15:0], i_data_byte};
                    n_bin   = bin_inc[STRIDE_W-1:0];
                end else begin
                    o_meta.bad = (hdr_last < hdr_first);
                    n_run      = o_meta.bad ? '0 : hdr_last - hdr_first;
                    n_bin      = HDR_BYTES;
                    end_row    = (n_run == '0);
                end
            end else begin
                // run of pixels after the header
                o_meta.kind = KIND_PIXEL;
                n_run       = run_dec;
                end_row     = (run_dec == '0);
            end

            // saturating offset
            if (r_off != OFFSET_MAX) begin
                n_off = r_off + 1'b1;
            end

            // row wrap and end of bitmap
            if (end_row) begin
                n_bin   = '0;
                n_shift = '0;
                n_run   = '0;
                n_row   = row_inc[DIM_W-1:0];
                if (row_inc >= {1'b0, r_rows}) begin
                    o_meta.done = 1'b1;
                    n_active    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= '0;
            r_cols    <= '0;
            r_row_len <= '0;
            r_hdr     <= 1'b0;
            r_active  <= 1'b0;
            r_row     <= '0;
            r_bin     <= '0;
            r_shift   <= '0;
            r_run     <= '0;
            r_off     <= '0;
        end else begin
            r_rows    <= n_rows;
            r_cols    <= n_cols;
            r_row_len <= n_row_len;
            r_hdr     <= n_hdr;
            r_active  <= n_active;
            r_row     <= n_row;
            r_bin     <= n_bin;
            r_shift   <= n_shift;
            r_run     <= n_run;
            r_off     <= n_off;
        end
    end

`ifndef SYNTH
    // a done word always ends the bitmap
    a_done_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_meta.done) |=> !r_active)
        else $error("bitmap stayed active after done word");

    // the row counter stays inside the latched row count while walking
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_row < r_rows))
        else $error("row counter beyond row count");

    // a bad header flag only marks a header byte
    a_bad_is_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_meta.bad) |-> (o_meta.kind == KIND_HEADER))
        else $error("bad header flag on a non-header byte");
`endif

endmodule

FILE: rtl/core/bitmap_row_remap_parser.sv
// ----------------------------------------------------------------------------
// bitmap_row_remap_parser
// Streams bitmap bytes through a loaded 256-entry remap table and tags each
// byte with its kind, row, row start, offset and end marks.
// ----------------------------------------------------------------------------
//  channel   signals                                     direction
//  -------   -----------------------------------------   ---------
//  input     i_in_valid / o_in_ready, opcode, index, byte in
//  output    o_out_valid / i_out_ready, byte and six tags       out
//  config    i_cfg_valid / o_cfg_ready, index, data      in
//
//  One word per cycle while the output is not stalled: a data word reads
//  the remap RAM at its accept edge, and its result moves on through the
//  holding stage to the output register. Table loads and starts give no
//  result. Output stalls back up through one holding stage; input stays ready
//  while that stage can drain. Reset clears the sequencer, not the table.
// ----------------------------------------------------------------------------
module bitmap_row_remap_parser
    import brrp_pkg::*;
#(
    parameter int MAX_DIMENSION = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_opcode,
    input  logic [TADDR_W-1:0]   i_table_index,
    input  logic [BYTE_W-1:0]    i_data_byte,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic [1:0]           o_byte_kind,
    output logic [ROW_W-1:0]     o_row_number,
    output logic                 o_row_begins,
    output logic [OFF_W-1:0]     o_byte_offset,
    output logic                 o_bitmap_done,
    output logic                 o_bad_header,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [STRIDE_W-1:0]  i_cfg_data
);

    t_cfg              r_cfg;
    logic              in_acc;
    logic              res_valid;
    t_meta             res_meta;
    logic [BYTE_W-1:0] ram_rdata;

    logic              r_s1_valid;
    t_meta             r_s1_meta;
    logic              s1_adv;

    logic              r_out_valid;
    t_meta             r_out_meta;
    logic [BYTE_W-1:0] r_out_byte;

    // configuration registers, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_cfg.width        <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_cfg.height       <= i_cfg_data[DIM_W-1:0];
                CFG_COLUMN: r_cfg.column_order <= i_cfg_data[0];
                CFG_HEADER: r_cfg.header_mode  <= i_cfg_data[0];
                CFG_STRIDE: r_cfg.stride       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake: take a word whenever the holding stage is empty or can move on
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // row sequencer
    brrp_ctrl #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_acc),
        .i_opcode    (i_opcode),
        .i_data_byte (i_data_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_meta      (res_meta)
    );

    // remap table, read only for data words that give a result
    brrp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_opcode == OP_LOAD)),
        .i_waddr (i_table_index),
        .i_wdata (i_data_byte),
        .i_re    (res_valid),
        .i_raddr (i_data_byte),
        .o_rdata (ram_rdata)
    );

    // stage 1: tags wait beside the table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (res_valid) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_s1_meta <= res_meta;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_meta <= r_s1_meta;
            r_out_byte <= (r_s1_meta.kind == KIND_PIXEL) ? ram_rdata : r_s1_meta.raw;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_byte_kind   = r_out_meta.kind;
    assign o_row_number  = r_out_meta.row;
    assign o_row_begins  = r_out_meta.begins;
    assign o_byte_offset = r_out_meta.offset;
    assign o_bitmap_done = r_out_meta.done;
    assign o_bad_header  = r_out_meta.bad;

`ifndef SYNTH
    // a full holding stage behind a stalled output blocks the input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input ready while pipeline is full");

    // a result word always moves into the output register next
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("holding stage drained without output word");

    // a table load never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_opcode == OP_LOAD)) |-> !res_valid)
        else $error("table load produced a result");
`endif

endmodule
